[design/slq_pkg.sv]
package slq_pkg;

    // Word memory size and the address width that follows from it.
    localparam int MEM_WORDS = 4096;
    localparam int ADDR_W    = $clog2(MEM_WORDS);

    // Program counter advance after a positive result.
    localparam logic [31:0] STEP_ADVANCE = 32'd3;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_EXEC  = 2'd2,
        ACT_SETPC = 2'd3
    } t_action;

    typedef struct packed {
        t_action            action;
        logic [11:0]        address;
        logic signed [31:0] data;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic signed [31:0] program_counter;
        logic               halted;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       wdata;
    } t_mem_req;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    // True when a signed 33-bit value is a valid word index.
    function automatic logic in_range(input logic [32:0] v);
        logic [32:0] lim;
        lim = 33'(MEM_WORDS);
        return !v[32] && (v < lim);
    endfunction

endpackage

[design/subleq_machine_step.sv]
// A write or a set-pc transaction returns its result from a register loaded at acceptance;
// a read passes through S_RDOUT, an execute through S_XPC to S_XPCU (refused in S_XPC or S_XCHK).
// One transaction at a time: busy stays low through a write or set-pc, and a read or an
// execute holds busy high until its result is returned.
// Reset (synchronous, active low) clears pc and the strobe, then a clearing pass over all
// MEM_WORDS words (4096) zeroes the memory while busy stays high. Results cannot be stalled.
module subleq_machine_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  slq_pkg::t_cmd     i_cmd,
    output logic              o_strobe,
    output slq_pkg::t_result  o_result
);
    import slq_pkg::*;

    // Sequencer states. The execute path walks through the three instruction
    // fetches, the two operand reads, the write back and the pc update, one
    // memory access and at most one adder operation per cycle.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDOUT,
        S_XPC,
        S_XB,
        S_XC,
        S_XCHK,
        S_XRB,
        S_XSUB,
        S_XPCU
    } t_state;

    t_state             r_state;
    logic [ADDR_W-1:0]  r_clr;
    logic [31:0]        r_pc;
    logic [31:0]        r_opa;
    logic [31:0]        r_opb;
    logic [31:0]        r_c;
    logic [31:0]        r_va;
    logic [31:0]        r_nv;
    logic               r_rd_ok;
    logic               r_strobe;
    t_result            r_res;

    t_mem_req           mem_req;
    logic [31:0]        mem_rdata;
    t_alu_op            alu_op;
    logic signed [31:0] alu_a;
    logic signed [31:0] alu_b;
    logic signed [32:0] alu_sum;
    logic [31:0]        cmd_addr_ext;
    logic               cmd_addr_ok;
    logic               ops_ok;
    logic               nv_positive;

    // The command address is zero extended so that it also works when the
    // memory is smaller than the address field can reach.
    assign cmd_addr_ext = 32'(i_cmd.address);
    assign cmd_addr_ok  = in_range({1'b0, cmd_addr_ext});
    assign ops_ok       = in_range({r_opa[31], r_opa}) && in_range({r_opb[31], r_opb});
    assign nv_positive  = !r_nv[31] && (r_nv != 32'd0);

    slq_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    slq_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum)
    );

    // The one adder serves the pc offsets, the bound check and the subtract.
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = r_pc;
        alu_b  = 32'sd0;
        unique case (r_state)
            S_XPC:   alu_b = 32'sd2;
            S_XB:    alu_b = 32'sd1;
            S_XC:    alu_b = 32'sd2;
            S_XSUB: begin
                alu_op = ALU_SUB;
                alu_a  = mem_rdata;
                alu_b  = r_va;
            end
            S_XPCU:  alu_b = STEP_ADVANCE;
            default: alu_b = 32'sd0;
        endcase
    end

    // Memory access for each state. Data read in one state shows up on
    // mem_rdata in the next one.
    always_comb begin
        mem_req.we    = 1'b0;
        mem_req.addr  = cmd_addr_ext[ADDR_W-1:0];
        mem_req.wdata = i_cmd.data;
        unique case (r_state)
            S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = r_clr;
                mem_req.wdata = 32'd0;
            end
            S_IDLE: begin
                mem_req.we = start && (i_cmd.action == ACT_WRITE) && cmd_addr_ok;
            end
            S_XPC:  mem_req.addr = r_pc[ADDR_W-1:0];
            S_XB:   mem_req.addr = alu_sum[ADDR_W-1:0];
            S_XC:   mem_req.addr = alu_sum[ADDR_W-1:0];
            S_XCHK: mem_req.addr = r_opa[ADDR_W-1:0];
            S_XRB:  mem_req.addr = r_opb[ADDR_W-1:0];
            S_XSUB: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = r_opb[ADDR_W-1:0];
                mem_req.wdata = alu_sum[31:0];
            end
            default: mem_req.we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pc     <= 32'd0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(MEM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        unique case (i_cmd.action)
                            ACT_WRITE: begin
                                r_strobe                <= 1'b1;
                                r_res.read_data         <= 32'sd0;
                                r_res.program_counter   <= r_pc;
                                r_res.halted            <= 1'b0;
                            end
                            ACT_READ: begin
                                r_rd_ok <= cmd_addr_ok;
                                r_state <= S_RDOUT;
                            end
                            ACT_SETPC: begin
                                r_pc                    <= i_cmd.data;
                                r_strobe                <= 1'b1;
                                r_res.read_data         <= 32'sd0;
                                r_res.program_counter   <= i_cmd.data;
                                r_res.halted            <= 1'b0;
                            end
                            ACT_EXEC: r_state <= S_XPC;
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RDOUT: begin
                    r_strobe              <= 1'b1;
                    r_res.read_data       <= r_rd_ok ? mem_rdata : 32'd0;
                    r_res.program_counter <= r_pc;
                    r_res.halted          <= 1'b0;
                    r_state               <= S_IDLE;
                end
                S_XPC: begin
                    // Refuse when pc is negative or the instruction runs past memory.
                    if (r_pc[31] || !in_range(alu_sum)) begin
                        r_strobe              <= 1'b1;
                        r_res.read_data       <= 32'sd0;
                        r_res.program_counter <= r_pc;
                        r_res.halted          <= 1'b1;
                        r_state               <= S_IDLE;
                    end else begin
                        r_state <= S_XB;
                    end
                end
                S_XB: begin
                    r_opa   <= mem_rdata;
                    r_state <= S_XC;
                end
                S_XC: begin
                    r_opb   <= mem_rdata;
                    r_state <= S_XCHK;
                end
                S_XCHK: begin
                    r_c <= mem_rdata;
                    // Both operand addresses must name a memory word.
                    if (!ops_ok) begin
                        r_strobe              <= 1'b1;
                        r_res.read_data       <= 32'sd0;
                        r_res.program_counter <= r_pc;
                        r_res.halted          <= 1'b1;
                        r_state               <= S_IDLE;
                    end else begin
                        r_state <= S_XRB;
                    end
                end
                S_XRB: begin
                    r_va    <= mem_rdata;
                    r_state <= S_XSUB;
                end
                S_XSUB: begin
                    r_nv    <= alu_sum[31:0];
                    r_state <= S_XPCU;
                end
                S_XPCU: begin
                    // A positive difference falls through, anything else jumps to C.
                    r_pc                  <= nv_positive ? alu_sum[31:0] : r_c;
                    r_strobe              <= 1'b1;
                    r_res.read_data       <= r_nv;
                    r_res.program_counter <= nv_positive ? alu_sum[31:0] : r_c;
                    r_res.halted          <= 1'b0;
                    r_state               <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // A result only ever follows an accepted transaction or work in progress.
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy || start))
        else $error("result strobe without a transaction");

    // No result is produced while the memory is being cleared.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_strobe)
        else $error("result strobe during memory clear");

    // An accepted transaction either completes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted transaction was dropped");

    // A refused execute reports no data.
    a_halt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.halted) |-> (o_result.read_data == 32'sd0))
        else $error("refused execute carries data");

    // The execute write back is followed by the pc update and then the result strobe.
    a_write_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XSUB) |=> (r_state == S_XPCU) ##1 o_strobe)
        else $error("execute write back did not complete");

endmodule

[design/slq_mem.sv]
module slq_mem (
    input  logic              i_clk,
    input  slq_pkg::t_mem_req i_req,
    output logic [31:0]       o_rdata
);
    import slq_pkg::*;

    logic [31:0] r_mem [MEM_WORDS];
    logic [31:0] r_rdata;

    // Single port, read data registered, read during write returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/slq_alu.sv]
module slq_alu (
    input  slq_pkg::t_alu_op    i_op,
    input  logic signed [31:0]  i_a,
    input  logic signed [31:0]  i_b,
    output logic signed [32:0]  o_sum
);
    import slq_pkg::*;

    logic signed [32:0] a_ext;
    logic signed [32:0] b_ext;

    assign a_ext = {i_a[31], i_a};
    assign b_ext = {i_b[31], i_b};

    // The result keeps one extra bit so range checks see no wrap.
    always_comb begin
        unique case (i_op)
            ALU_ADD: o_sum = a_ext + b_ext;
            ALU_SUB: o_sum = a_ext - b_ext;
            default: o_sum = a_ext + b_ext;
        endcase
    end

endmodule

[verif/tb_subleq_machine_step.sv]
module tb_subleq_machine_step;
    timeunit 1ns;
    timeprecision 1ps;

    import slq_pkg::*;

    // Cycles without any accepted transaction or result before the run is declared hung.
    // The clearing pass after reset, over all MEM_WORDS words, counts as quiet time.
    localparam int QUIET_LIMIT = 4 * MEM_WORDS + 2000;
    // Number of random commands after the directed table.
    localparam int RANDOM_ITEMS = 800;
    // Most random program traffic stays inside this small window, so that
    // operand words written there point back into memory and instructions run.
    localparam int WINDOW = 32;
    // Cycles allowed after the last result for stray strobes to show up.
    localparam int TAIL_CYCLES = 20;

    // One row of the directed table. When known is set, the expected result
    // is written into the row instead of being taken from the predictor.
    typedef struct {
        t_cmd    cmd;
        bit      known;
        t_result want;
    } t_plan_row;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    logic    busy;
    t_cmd    i_cmd   = '0;
    logic    o_strobe;
    t_result o_result;

    // Side channel that travels with the command: a typed-in expectation.
    // It is driven with nonblocking assignments exactly like the command.
    bit      pin_valid  = 1'b0;
    t_result pin_result = '0;

    // Predictor state: the word memory and the program counter as the
    // machine should hold them after every accepted transaction.
    logic [31:0]        word_model [0:MEM_WORDS-1];
    logic signed [31:0] pc_model;

    // Results that the block still owes us, oldest first.
    t_result pending_results [$];
    int      mismatches  = 0;
    int      quiet_cycles = 0;

    t_plan_row directed_rows [$];

    subleq_machine_step u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Executes one command against the predictor state and returns the result
    // the block must report for it.
    function automatic t_result step_machine(input t_cmd c);
        t_result            r;
        int                 pc_i;
        logic signed [31:0] opnd_a;
        logic signed [31:0] opnd_b;
        logic [31:0]        target;
        logic [31:0]        diff;
        r = '0;
        case (c.action)
            ACT_WRITE: begin
                if (c.address < MEM_WORDS) word_model[c.address] = c.data;
            end
            ACT_READ: begin
                if (c.address < MEM_WORDS) r.read_data = word_model[c.address];
            end
            ACT_SETPC: begin
                pc_model = c.data;
            end
            default: begin
                pc_i = pc_model;
                // The whole instruction (three words) has to sit inside memory.
                if (pc_i < 0 || pc_i > MEM_WORDS - 3) begin
                    r.halted = 1'b1;
                end else begin
                    opnd_a = word_model[pc_i];
                    opnd_b = word_model[pc_i + 1];
                    // The jump target is fetched before the write, since B may
                    // point at the instruction's own third word.
                    target = word_model[pc_i + 2];
                    if (opnd_a < 0 || opnd_a >= MEM_WORDS ||
                        opnd_b < 0 || opnd_b >= MEM_WORDS) begin
                        r.halted = 1'b1;
                    end else begin
                        diff = word_model[opnd_b] - word_model[opnd_a];
                        word_model[opnd_b] = diff;
                        r.read_data = diff;
                        if ($signed(diff) > 0) begin
                            pc_model = pc_model + STEP_ADVANCE;
                        end else begin
                            pc_model = target;
                        end
                    end
                end
            end
        endcase
        r.program_counter = pc_model;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
                     $time, name, want, want, got, got);
        end
    endtask

    // Result checker, command tracker and watchdog. Everything here samples
    // the values that were present just before the rising edge, so the order
    // in which processes wake up at the edge does not matter. A result is
    // checked before the command accepted at the same edge is predicted; the
    // block cannot answer a transaction in the cycle that accepts it.
    always @(posedge i_clk) begin : track_results
        t_result want;
        bit      took_cmd;
        if (i_rst_n) begin
            took_cmd = start && (busy === 1'b0);
            if (o_strobe === 1'b1) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no transaction pending, %s %0d pc %0d halted %0b",
                             $time, "read_data", o_result.read_data,
                             o_result.program_counter, o_result.halted);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("read_data", want.read_data, o_result.read_data);
                    compare_field("program_counter", want.program_counter,
                                  o_result.program_counter);
                    compare_field("halted", 32'(want.halted), 32'(o_result.halted));
                end
            end
            if (took_cmd) begin
                // The predictor always runs so that its state follows the
                // block; a typed-in expectation only replaces what it says.
                want = step_machine(i_cmd);
                if (pin_valid) want = pin_result;
                pending_results.push_back(want);
            end
            if (took_cmd || o_strobe === 1'b1) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    function automatic t_plan_row predicted_row(input t_action act, input int addr,
                                                input logic [31:0] data);
        t_plan_row p;
        p.cmd.action  = act;
        p.cmd.address = 12'(addr);
        p.cmd.data    = data;
        p.known       = 1'b0;
        p.want        = '0;
        return p;
    endfunction

    function automatic t_plan_row known_row(input t_action act, input int addr,
                                            input logic [31:0] data,
                                            input logic [31:0] rd,
                                            input logic [31:0] pc, input bit h);
        t_plan_row p;
        p = predicted_row(act, addr, data);
        p.known                = 1'b1;
        p.want.read_data       = rd;
        p.want.program_counter = pc;
        p.want.halted          = h;
        return p;
    endfunction

    // Random command. Most traffic builds and runs small programs inside the
    // window; the rest is writes and reads anywhere, and wild program counters.
    function automatic t_cmd random_cmd();
        t_cmd c;
        int   pick;
        c.address = 12'($urandom);
        c.data    = $urandom;
        pick      = $urandom_range(0, 99);
        if (pick < 35) begin
            c.action = ACT_EXEC;
        end else if (pick < 57) begin
            c.action  = ACT_WRITE;
            c.address = 12'($urandom_range(0, WINDOW - 1));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: c.data = $urandom_range(0, WINDOW - 1);
                6:       c.data = $urandom;
                7:       c.data = 0 - $urandom_range(1, 4);
                8:       c.data = $urandom_range(MEM_WORDS - 4, MEM_WORDS + 3);
                default: begin
                    case ($urandom_range(0, 3))
                        0:       c.data = 32'h7FFF_FFFF;
                        1:       c.data = 32'h8000_0000;
                        2:       c.data = 32'h0000_0001;
                        default: c.data = 32'h0000_0000;
                    endcase
                end
            endcase
        end else if (pick < 65) begin
            c.action = ACT_WRITE;
        end else if (pick < 80) begin
            c.action = ACT_READ;
            if ($urandom_range(0, 9) < 7) c.address = 12'($urandom_range(0, WINDOW - 1));
        end else begin
            c.action = ACT_SETPC;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: c.data = $urandom_range(0, WINDOW - 1);
                7:       c.data = MEM_WORDS - $urandom_range(1, 4);
                8:       c.data = 0 - $urandom_range(1, 8);
                default: c.data = $urandom;
            endcase
        end
        return c;
    endfunction

    // Presents one command and holds it until the block accepts it. Start
    // stays high on return, so a following command in the same burst goes
    // out back to back.
    task automatic issue(input t_cmd c, input bit known, input t_result want);
        start      <= 1'b1;
        i_cmd      <= c;
        pin_valid  <= known;
        pin_result <= want;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stops sending until the block has answered every transaction so far.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    initial begin : stimulus
        int sent;
        int burst;
        for (int i = 0; i < MEM_WORDS; i++) word_model[i] = '0;
        pc_model = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. From reset, memory and pc are zero, so the first
        // rows can be read off directly. An all-zero instruction subtracts
        // word 0 from itself, gets zero, and jumps to C, which is also zero.
        directed_rows.push_back(known_row(ACT_READ, 0, 32'h0, 32'h0, 32'h0, 1'b0));
        directed_rows.push_back(known_row(ACT_READ, 4095, 32'h0, 32'h0, 32'h0, 1'b0));
        directed_rows.push_back(known_row(ACT_EXEC, 0, 32'h0, 32'h0, 32'h0, 1'b0));
        // Negative program counters are accepted, but executing there is refused.
        directed_rows.push_back(known_row(ACT_SETPC, 0, 32'hFFFF_FFFF,
                                          32'h0, 32'hFFFF_FFFF, 1'b0));
        directed_rows.push_back(known_row(ACT_EXEC, 0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1));
        directed_rows.push_back(known_row(ACT_SETPC, 0, 32'h8000_0000,
                                          32'h0, 32'h8000_0000, 1'b0));
        directed_rows.push_back(known_row(ACT_EXEC, 0, 32'h0, 32'h0, 32'h8000_0000, 1'b1));
        // At the top of memory the instruction no longer fits one word too early,
        // and just fits at the last legal position.
        directed_rows.push_back(known_row(ACT_SETPC, 0, 32'd4094, 32'h0, 32'd4094, 1'b0));
        directed_rows.push_back(known_row(ACT_EXEC, 0, 32'h0, 32'h0, 32'd4094, 1'b1));
        directed_rows.push_back(known_row(ACT_SETPC, 0, 32'd4093, 32'h0, 32'd4093, 1'b0));
        directed_rows.push_back(known_row(ACT_EXEC, 0, 32'h0, 32'h0, 32'h0, 1'b0));
        // Extreme data words at the highest addresses.
        directed_rows.push_back(known_row(ACT_WRITE, 4095, 32'h7FFF_FFFF,
                                          32'h0, 32'h0, 1'b0));
        directed_rows.push_back(known_row(ACT_READ, 4095, 32'h0, 32'h7FFF_FFFF,
                                          32'h0, 1'b0));
        directed_rows.push_back(known_row(ACT_WRITE, 4094, 32'h8000_0000,
                                          32'h0, 32'h0, 1'b0));
        directed_rows.push_back(known_row(ACT_READ, 4094, 32'h0, 32'h8000_0000,
                                          32'h0, 1'b0));
        // A real instruction whose subtraction wraps from the most negative word
        // to the most positive one, so pc advances by three.
        directed_rows.push_back(predicted_row(ACT_WRITE, 0, 32'd10));
        directed_rows.push_back(predicted_row(ACT_WRITE, 1, 32'd11));
        directed_rows.push_back(predicted_row(ACT_WRITE, 2, 32'd100));
        directed_rows.push_back(predicted_row(ACT_WRITE, 10, 32'd1));
        directed_rows.push_back(predicted_row(ACT_WRITE, 11, 32'h8000_0000));
        directed_rows.push_back(predicted_row(ACT_EXEC, 0, 32'h0));
        // Operand A negative, then operand B one past the end of memory.
        directed_rows.push_back(predicted_row(ACT_WRITE, 0, 32'hFFFF_FFFF));
        directed_rows.push_back(known_row(ACT_SETPC, 0, 32'h0, 32'h0, 32'h0, 1'b0));
        directed_rows.push_back(known_row(ACT_EXEC, 0, 32'h0, 32'h0, 32'h0, 1'b1));
        directed_rows.push_back(predicted_row(ACT_WRITE, 0, 32'd10));
        directed_rows.push_back(predicted_row(ACT_WRITE, 1, MEM_WORDS));
        directed_rows.push_back(known_row(ACT_EXEC, 0, 32'h0, 32'h0, 32'h0, 1'b1));

        foreach (directed_rows[i]) begin
            issue(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].want);
            idle_for($urandom_range(0, 3));
        end

        // Let the block go fully quiet once before the random traffic starts.
        drain_results();

        // Random traffic in bursts. Gaps between bursts have random length so
        // that the next transaction lands on every phase of an execute, and
        // about a quarter of the bursts follow each other with no gap at all.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                issue(random_cmd(), 1'b0, '0);
                sent++;
            end
            if ($urandom_range(0, 29) == 0) begin
                drain_results();
            end else if ($urandom_range(0, 3) != 0) begin
                idle_for($urandom_range(1, 12));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
